@@ rtl/spre_pkg.sv @@
package spre_pkg;

  localparam int DEF_MAX_NODES   = 64;
  localparam int DEF_MAX_EDGES   = 1024;
  localparam int DEF_WEIGHT_BITS = 32;

  localparam int NODE_BITS      = 6;
  localparam int DIST_BITS      = 64;
  localparam int CFG_DATA_BITS  = 7;
  localparam int CFG_INDEX_BITS = 1;

  // command codes
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // vertex status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNREACH = 2'd1;
  localparam logic [1:0] ST_NEGINF  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NODE_COUNT = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNDIRECTED = 1'd1;

  typedef struct packed {
    logic [1:0]                  cmd;
    logic [NODE_BITS-1:0]        from_node;
    logic [NODE_BITS-1:0]        to_node;
    logic signed [31:0]          edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]        node_index;
    logic signed [DIST_BITS-1:0] distance;
    logic [1:0]                  node_status;
    logic                        negative_cycle;
    logic                        edges_dropped;
    logic                        last_node;
  } result_t;

  // one entry of the distance store
  typedef struct packed {
    logic [1:0]                  status;
    logic signed [DIST_BITS-1:0] path_len;
  } dist_entry_t;

endpackage

@@ rtl/shortest_path_relaxation_engine.sv @@
// Add edge: undirected mode adds the reverse edge in state S_ADD2 (one edge-store write port).
// Run: initialize distances, then 2n-1 passes over the edge store with, per edge, at most
// edge read, distance read, saturating add, compare and write back, then per result a
// distance read, an output register load and a wait for the transfer; input is not ready during a run.
// Reset (synchronous, active high) empties the edge store, clears the drop flag and sets
// node_count to 1 and undirected_mode to 1; edge and distance memories are not cleared.
module shortest_path_relaxation_engine #(
  parameter int MAX_NODES   = spre_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES   = spre_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = spre_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  spre_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output spre_pkg::result_t                   out_data,
  input  logic                                cfg_write,
  input  logic [spre_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [spre_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  import spre_pkg::*;

  localparam int NIDX_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int PASS_W = $clog2(2 * MAX_NODES);
  localparam int EA_W   = $clog2(MAX_EDGES);
  localparam int ET_W   = $clog2(MAX_EDGES + 1);
  localparam int CMP_W  = NODE_BITS + 1;
  localparam int EW     = 2 * NODE_BITS + WEIGHT_BITS;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_ADD2   = 10'b0000000010,
    S_INIT   = 10'b0000000100,
    S_EFETCH = 10'b0000001000,
    S_EREAD  = 10'b0000010000,
    S_CALC   = 10'b0000100000,
    S_UPDATE = 10'b0001000000,
    S_ORD    = 10'b0010000000,
    S_OLOAD  = 10'b0100000000,
    S_OWAIT  = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_adv;

  logic [CFG_DATA_BITS-1:0] node_count;
  logic                     undirected_mode;

  logic [CNT_W-1:0]     n_q;
  logic [NODE_BITS-1:0] start_q;
  logic                 start_ok;
  logic [PASS_W-1:0]    mark_from;
  logic [PASS_W-1:0]    last_pass;
  logic [PASS_W-1:0]    pass;
  logic [PASS_W-1:0]    pass_adv;
  logic [ET_W-1:0]      e;
  logic [ET_W-1:0]      e_adv;
  logic [NIDX_W-1:0]    idx;
  logic [ET_W-1:0]      edge_total;
  logic                 overflow_flag;
  logic                 neg_flag;

  logic [NODE_BITS-1:0]   add_src;
  logic [NODE_BITS-1:0]   add_dst;
  logic [WEIGHT_BITS-1:0] add_w;

  logic                   in_xfer;
  logic [DIST_BITS-1:0]   w_raw;
  logic [WEIGHT_BITS-1:0] w_in;
  logic                   full;
  logic [CNT_W-1:0]       n_eff;
  logic                   idx_last;
  logic                   marking;

  logic                   ewe;
  logic [EW-1:0]          ewdata;
  logic [EW-1:0]          erdata;
  logic [NODE_BITS-1:0]   e_src;
  logic [NODE_BITS-1:0]   e_dst;
  logic [WEIGHT_BITS-1:0] e_w;
  logic                   e_skip;

  logic              dwe;
  logic [NIDX_W-1:0] dwaddr;
  dist_entry_t       dwdata;
  logic              dre;
  logic [NIDX_W-1:0] draddr_a;
  dist_entry_t       drdata_a;
  dist_entry_t       drdata_b;

  logic signed [DIST_BITS-1:0] cand;
  logic                        better;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign w_raw    = {32'b0, in_data.edge_weight};
  assign w_in     = w_raw[WEIGHT_BITS-1:0];
  assign full     = (edge_total == ET_W'(MAX_EDGES));
  assign idx_last = (CNT_W'(idx) == (n_q - CNT_W'(1)));
  assign marking  = (pass >= mark_from);

  // clamp node_count into 1..MAX_NODES
  always_comb begin
    if (node_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (node_count > CFG_DATA_BITS'(MAX_NODES)) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = CNT_W'(node_count);
    end
  end

  // edge store
  always_comb begin
    ewe    = 1'b0;
    ewdata = {add_src, add_dst, add_w};
    if (in_xfer && (in_data.cmd == CMD_ADD)) begin
      ewe    = !full;
      ewdata = {in_data.from_node, in_data.to_node, w_in};
    end else if (state == S_ADD2) begin
      ewe = !full;
    end
  end

  spre_edge_mem #(
    .DEPTH(MAX_EDGES),
    .WIDTH(EW)
  ) u_edge_mem (
    .clk  (clk),
    .we   (ewe),
    .waddr(edge_total[EA_W-1:0]),
    .wdata(ewdata),
    .re   (state == S_EFETCH),
    .raddr(e[EA_W-1:0]),
    .rdata(erdata)
  );

  assign e_src  = erdata[EW-1 -: NODE_BITS];
  assign e_dst  = erdata[EW-NODE_BITS-1 -: NODE_BITS];
  assign e_w    = erdata[WEIGHT_BITS-1:0];
  assign e_skip = (CMP_W'(e_src) >= CMP_W'(n_q)) || (CMP_W'(e_dst) >= CMP_W'(n_q));

  // distance store
  always_comb begin
    dre      = 1'b0;
    draddr_a = e_src[NIDX_W-1:0];
    if ((state == S_EREAD) && !e_skip) begin
      dre = 1'b1;
    end else if (state == S_ORD) begin
      dre      = 1'b1;
      draddr_a = idx;
    end
  end

  always_comb begin
    dwe             = 1'b0;
    dwaddr          = e_dst[NIDX_W-1:0];
    dwdata.status   = ST_NEGINF;
    dwdata.path_len = '0;
    case (state)
      S_INIT: begin
        dwe    = 1'b1;
        dwaddr = idx;
        if (start_ok && (CMP_W'(idx) == CMP_W'(start_q))) begin
          dwdata.status = ST_OK;
        end else begin
          dwdata.status = ST_UNREACH;
        end
      end
      S_CALC: begin
        dwe = (drdata_a.status == ST_NEGINF);
      end
      S_UPDATE: begin
        dwe = better;
        if (!marking) begin
          dwdata.status   = ST_OK;
          dwdata.path_len = cand;
        end
      end
      default: begin
      end
    endcase
  end

  spre_dist_mem #(
    .DEPTH(MAX_NODES)
  ) u_dist_mem (
    .clk    (clk),
    .we     (dwe),
    .waddr  (dwaddr),
    .wdata  (dwdata),
    .re     (dre),
    .raddr_a(draddr_a),
    .raddr_b(e_dst[NIDX_W-1:0]),
    .rdata_a(drdata_a),
    .rdata_b(drdata_b)
  );

  spre_relax_unit #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_relax (
    .clk    (clk),
    .load   (state == S_CALC),
    .dist_a (drdata_a.path_len),
    .weight ($signed(e_w)),
    .entry_b(drdata_b),
    .cand   (cand),
    .better (better)
  );

  // advance to the next edge, the next pass, or the output sweep
  always_comb begin
    e_adv     = e + ET_W'(1);
    pass_adv  = pass;
    state_adv = S_EFETCH;
    if (e_adv == edge_total) begin
      e_adv = '0;
      if (pass == last_pass) begin
        state_adv = S_ORD;
      end else begin
        pass_adv = pass + PASS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      node_count      <= CFG_DATA_BITS'(1);
      undirected_mode <= 1'b1;
      edge_total      <= '0;
      overflow_flag   <= 1'b0;
      neg_flag        <= 1'b0;
      out_valid       <= 1'b0;
      idx             <= '0;
      pass            <= '0;
      e               <= '0;
      n_q             <= CNT_W'(1);
      start_ok        <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_NODE_COUNT: node_count      <= cfg_data;
          CFG_UNDIRECTED: undirected_mode <= cfg_data[0];
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            case (in_data.cmd)
              CMD_ADD: begin
                if (full) begin
                  overflow_flag <= 1'b1;
                end else begin
                  edge_total <= edge_total + ET_W'(1);
                end
                if (undirected_mode) begin
                  add_src <= in_data.to_node;
                  add_dst <= in_data.from_node;
                  add_w   <= w_in;
                  state   <= S_ADD2;
                end
              end
              CMD_RUN: begin
                n_q       <= n_eff;
                start_q   <= in_data.from_node;
                start_ok  <= (CMP_W'(in_data.from_node) < CMP_W'(n_eff));
                mark_from <= PASS_W'(n_eff) - PASS_W'(1);
                last_pass <= (PASS_W'(n_eff) << 1) - PASS_W'(2);
                neg_flag  <= 1'b0;
                idx       <= '0;
                state     <= S_INIT;
              end
              CMD_CLEAR: begin
                edge_total    <= '0;
                overflow_flag <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD2: begin
          if (full) begin
            overflow_flag <= 1'b1;
          end else begin
            edge_total <= edge_total + ET_W'(1);
          end
          state <= S_IDLE;
        end
        S_INIT: begin
          if (idx_last) begin
            idx  <= '0;
            pass <= '0;
            e    <= '0;
            if (start_ok && (edge_total != '0)) begin
              state <= S_EFETCH;
            end else begin
              state <= S_ORD;
            end
          end else begin
            idx <= idx + NIDX_W'(1);
          end
        end
        S_EFETCH: begin
          state <= S_EREAD;
        end
        S_EREAD: begin
          if (e_skip) begin
            e     <= e_adv;
            pass  <= pass_adv;
            state <= state_adv;
          end else begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (drdata_a.status == ST_OK) begin
            state <= S_UPDATE;
          end else begin
            e     <= e_adv;
            pass  <= pass_adv;
            state <= state_adv;
          end
        end
        S_UPDATE: begin
          if (better && marking) begin
            neg_flag <= 1'b1;
          end
          e     <= e_adv;
          pass  <= pass_adv;
          state <= state_adv;
        end
        S_ORD: begin
          state <= S_OLOAD;
        end
        S_OLOAD: begin
          out_data.node_index     <= NODE_BITS'(idx);
          out_data.distance       <= (drdata_a.status == ST_OK) ? drdata_a.path_len : '0;
          out_data.node_status    <= drdata_a.status;
          out_data.negative_cycle <= neg_flag;
          out_data.edges_dropped  <= overflow_flag;
          out_data.last_node      <= idx_last;
          out_valid               <= 1'b1;
          state                   <= S_OWAIT;
        end
        S_OWAIT: begin
          // hold the result until the transfer
          if (out_ready) begin
            out_valid <= 1'b0;
            if (idx_last) begin
              idx   <= '0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + NIDX_W'(1);
              state <= S_ORD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/spre_edge_mem.sv @@
module spre_edge_mem #(
  parameter int DEPTH = spre_pkg::DEF_MAX_EDGES,
  parameter int WIDTH = 2 * spre_pkg::NODE_BITS + spre_pkg::DEF_WEIGHT_BITS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/spre_dist_mem.sv @@
module spre_dist_mem #(
  parameter int DEPTH = spre_pkg::DEF_MAX_NODES
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  spre_pkg::dist_entry_t    wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output spre_pkg::dist_entry_t    rdata_a,
  output spre_pkg::dist_entry_t    rdata_b
);

  import spre_pkg::*;

  dist_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/spre_relax_unit.sv @@
module spre_relax_unit #(
  parameter int WEIGHT_BITS = spre_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                    clk,
  input  logic                                    load,
  input  logic signed [spre_pkg::DIST_BITS-1:0]   dist_a,
  input  logic signed [WEIGHT_BITS-1:0]           weight,
  input  spre_pkg::dist_entry_t                   entry_b,
  output logic signed [spre_pkg::DIST_BITS-1:0]   cand,
  output logic                                    better
);

  import spre_pkg::*;

  localparam logic signed [DIST_BITS:0] SAT_HI = {2'b00, {(DIST_BITS-1){1'b1}}};
  localparam logic signed [DIST_BITS:0] SAT_LO = -SAT_HI;

  logic signed [DIST_BITS:0] sum;

  assign sum = (DIST_BITS+1)'(dist_a) + (DIST_BITS+1)'(weight);

  // saturate to the symmetric distance range
  always_ff @(posedge clk) begin
    if (load) begin
      if (sum > SAT_HI) begin
        cand <= SAT_HI[DIST_BITS-1:0];
      end else if (sum < SAT_LO) begin
        cand <= SAT_LO[DIST_BITS-1:0];
      end else begin
        cand <= sum[DIST_BITS-1:0];
      end
    end
  end

  assign better = (entry_b.status == ST_UNREACH) ||
                  ((entry_b.status == ST_OK) && (entry_b.path_len > cand));

endmodule
